// File: rtl/core/pulse_rate_detector_core_macros.svh
// assertion macros for the pulse rate detector core
`ifndef PULSE_RATE_DETECTOR_CORE_MACROS_SVH
`define PULSE_RATE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/prd_pkg.sv
// types and constants shared by the pulse rate detector core
package prd_pkg;

	localparam int SAMPLE_W = 12;
	localparam int RATE_W   = 16;
	localparam int CFG_W    = 16;
	localparam int INDEX_W  = 3;
	localparam int STEP_W   = $clog2(RATE_W);
	localparam int SUM_W    = RATE_W + 2;
	localparam int RECIP_W  = 18;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int MEAN_SHIFT = 19;
	localparam logic [RECIP_W-1:0] MEAN_RECIP = 18'd174763;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [INDEX_W-1:0] REG_BEAT_THRESHOLD = 3'd0;
	localparam logic [INDEX_W-1:0] REG_HYSTERESIS     = 3'd1;
	localparam logic [INDEX_W-1:0] REG_RATE_NUMERATOR = 3'd2;
	localparam logic [INDEX_W-1:0] REG_BAND_LOW       = 3'd3;
	localparam logic [INDEX_W-1:0] REG_BAND_OK        = 3'd4;
	localparam logic [INDEX_W-1:0] REG_BAND_HIGH      = 3'd5;
	localparam logic [INDEX_W-1:0] REG_BAND_VERY_HIGH = 3'd6;

	typedef enum logic [2:0] {
		ST_VERY_LOW  = 3'd0,
		ST_LOW       = 3'd1,
		ST_OK        = 3'd2,
		ST_HIGH      = 3'd3,
		ST_VERY_HIGH = 3'd4,
		ST_SKIPPED   = 3'd5
	} rate_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_SUM,
		S_MUL,
		S_FIN,
		S_WRITE
	} ctrl_state_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] beat_threshold;
		logic [SAMPLE_W-1:0] hysteresis;
		logic [RATE_W-1:0]   rate_numerator;
		logic [RATE_W-1:0]   band_low;
		logic [RATE_W-1:0]   band_ok;
		logic [RATE_W-1:0]   band_high;
		logic [RATE_W-1:0]   band_very_high;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic latch;
		logic eval;
		logic div_start;
		logic div_step;
		logic sum;
		logic mul;
		logic fin;
		logic write;
	} dp_cmd_t;

	typedef struct packed {
		logic beat_now;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/core/prd_chan_if.sv
// input and result channel interfaces of the pulse rate detector core
interface prd_in_if import prd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, command, sample, input ready);
	modport sink (input valid, command, sample, output ready);
endinterface

interface prd_out_if import prd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              beat;
	logic [RATE_W-1:0] rate_bpm;
	logic [RATE_W-1:0] mean_bpm;
	logic [2:0]        status;
	logic              skipped;

	modport source (output valid, beat, rate_bpm, mean_bpm, status, skipped, input ready);
	modport sink (input valid, beat, rate_bpm, mean_bpm, status, skipped, output ready);
endinterface

// File: rtl/core/pulse_rate_detector_core.sv
// top level of the pulse rate detector core
//
// feed carries one item per transfer: a command bit (sample or clear skip flag)
// and a 12-bit sensor sample. report carries one result per accepted item:
// beat, latest rate, mean of the last three rates, band status and the sticky
// skip flag. configuration is written through wr_en / wr_index / wr_data; the
// user must write it only while the block is idle, the block itself does not
// enforce it. one write per cycle, no read-back. items are handled one at a
// time. a clear or a sample without a beat passes the evaluate and write
// states; a beat also runs the restoring divider, one of the 16 rate bits
// per cycle, then a sum and a reciprocal multiply for the mean of three.
// feed.ready is high whenever the controller is idle, also while a result
// waits in the output register; a stalled receiver holds that result and
// the next item then waits before its own result is written.
// reset clears the detector state and restores the register defaults.
`include "pulse_rate_detector_core_macros.svh"

module pulse_rate_detector_core import prd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	prd_in_if.sink             feed,
	prd_out_if.source          report,
	input  logic               wr_en,
	input  logic [INDEX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]   wr_data
);

	cfg_t         cfg;
	dp_cmd_t      cmd;
	dp_stat_t     stat;
	rate_status_t out_status;

	prd_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	prd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feed.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	prd_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.in_command  (feed.command),
		.in_sample   (feed.sample),
		.out_valid   (report.valid),
		.out_ready   (report.ready),
		.out_beat    (report.beat),
		.out_rate    (report.rate_bpm),
		.out_mean    (report.mean_bpm),
		.out_status  (out_status),
		.out_skipped (report.skipped)
	);

	assign feed.ready    = cmd.idle;
	assign report.status = out_status;

	`PRD_ASSERT_NEXT(a_busy_after_transfer, feed.valid && feed.ready, !feed.ready, "ready after transfer")
	`PRD_ASSERT_IMPL(a_beat_skip_status, report.valid && report.beat && report.skipped, report.status == ST_SKIPPED, "skip flag without skipped status")
	`PRD_ASSERT_IMPL(a_result_after_busy, $rose(report.valid), !$past(feed.ready), "result without work")

endmodule

// File: rtl/core/prd_cfg_regs.sv
// configuration register file of the pulse rate detector core
module prd_cfg_regs import prd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [INDEX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]   wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_threshold <= 12'd2650;
			cfg_q.hysteresis     <= 12'd100;
			cfg_q.rate_numerator <= 16'd12000;
			cfg_q.band_low       <= 16'd30;
			cfg_q.band_ok        <= 16'd45;
			cfg_q.band_high      <= 16'd80;
			cfg_q.band_very_high <= 16'd100;
		end else if (wr_en) begin
			case (wr_index)
				REG_BEAT_THRESHOLD: cfg_q.beat_threshold <= wr_data[SAMPLE_W-1:0];
				REG_HYSTERESIS:     cfg_q.hysteresis     <= wr_data[SAMPLE_W-1:0];
				REG_RATE_NUMERATOR: cfg_q.rate_numerator <= wr_data[RATE_W-1:0];
				REG_BAND_LOW:       cfg_q.band_low       <= wr_data[RATE_W-1:0];
				REG_BAND_OK:        cfg_q.band_ok        <= wr_data[RATE_W-1:0];
				REG_BAND_HIGH:      cfg_q.band_high      <= wr_data[RATE_W-1:0];
				REG_BAND_VERY_HIGH: cfg_q.band_very_high <= wr_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/prd_divider.sv
// restoring divider, one quotient bit per cycle while step is high
module prd_divider import prd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   start,
	input  logic                   step,
	input  logic [RATE_W-1:0]      dividend,
	input  logic [COUNT_WIDTH-1:0] divisor,
	output logic [RATE_W-1:0]      quotient
);

	localparam int RW = ((COUNT_WIDTH > RATE_W) ? COUNT_WIDTH : RATE_W) + 1;

	logic [RW-2:0]          rem_q;
	logic [RATE_W-1:0]      quot_q;
	logic [COUNT_WIDTH-1:0] div_q;
	logic [RW-1:0]          shifted;
	logic [RW-1:0]          div_ext;
	logic [RW-1:0]          diff;
	logic                   ge;

	always_comb begin
		shifted = {rem_q, quot_q[RATE_W-1]};
		div_ext = RW'(div_q);
		ge      = (shifted >= div_ext);
		diff    = shifted - div_ext;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			div_q  <= divisor;
		end else if (step) begin
			rem_q  <= ge ? diff[RW-2:0] : shifted[RW-2:0];
			quot_q <= {quot_q[RATE_W-2:0], ge};
		end
	end

	assign quotient = quot_q;

endmodule

// File: rtl/core/prd_datapath.sv
// beat detection state, rate, mean, skip test and result register
module prd_datapath import prd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                in_command,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_beat,
	output logic [RATE_W-1:0]   out_rate,
	output logic [RATE_W-1:0]   out_mean,
	output rate_status_t        out_status,
	output logic                out_skipped
);

	localparam int SW = COUNT_WIDTH + 4;

	logic                   cmd_q;
	logic [SAMPLE_W-1:0]    sample_q;
	logic                   beat_q;
	logic                   armed_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] past_int_q [2];
	logic [RATE_W-1:0]      past_rate_q [2];
	logic [RATE_W-1:0]      latest_q;
	logic [RATE_W-1:0]      mean_q;
	rate_status_t           status_q;
	logic                   skip_q;
	logic [COUNT_WIDTH-1:0] divisor_q;
	logic [SUM_W-1:0]       sum_q;
	logic [PROD_W-1:0]      prod_q;

	logic                   out_valid_q;
	logic                   out_beat_q;
	logic [RATE_W-1:0]      out_rate_q;
	logic [RATE_W-1:0]      out_mean_q;
	rate_status_t           out_status_q;
	logic                   out_skipped_q;

	logic [RATE_W-1:0]      quot;
	logic [COUNT_WIDTH-1:0] next_count;
	logic                   beat_now;
	logic                   rearm;
	logic [SAMPLE_W:0]      level_sum;
	logic [SW-1:0]          new5;
	logic [SW-1:0]          old9_0;
	logic [SW-1:0]          old9_1;
	logic                   skip_hit;
	logic                   skip_next;
	rate_status_t           band;

	prd_divider #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_divider (
		.clk      (clk),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (cfg.rate_numerator),
		.divisor  (next_count),
		.quotient (quot)
	);

	always_comb begin
		next_count = (count_q == '1) ? count_q : count_q + 1'b1;
		beat_now   = (cmd_q == CMD_SAMPLE) && !armed_q && (sample_q > cfg.beat_threshold);
		level_sum  = {1'b0, sample_q} + {1'b0, cfg.hysteresis};
		rearm      = armed_q && (level_sum < {1'b0, cfg.beat_threshold});
		new5       = ({4'b0, divisor_q} << 2) + {4'b0, divisor_q};
		old9_0     = ({4'b0, past_int_q[0]} << 3) + {4'b0, past_int_q[0]};
		old9_1     = ({4'b0, past_int_q[1]} << 3) + {4'b0, past_int_q[1]};
		skip_hit   = (new5 >= old9_1) && (new5 >= old9_0);
		skip_next  = skip_q || skip_hit;
		if (quot < cfg.band_low) begin
			band = ST_VERY_LOW;
		end else if (quot < cfg.band_ok) begin
			band = ST_LOW;
		end else if (quot >= cfg.band_ok && quot < cfg.band_high) begin
			band = ST_OK;
		end else if (quot >= cfg.band_high && quot < cfg.band_very_high) begin
			band = ST_HIGH;
		end else if (quot >= cfg.band_very_high) begin
			band = ST_VERY_HIGH;
		end else begin
			band = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q    <= in_command;
			sample_q <= in_sample;
		end
		if (cmd.eval) begin
			divisor_q <= next_count;
		end
		if (cmd.sum) begin
			sum_q <= SUM_W'(past_rate_q[0]) + SUM_W'(past_rate_q[1]) + SUM_W'(quot);
		end
		if (cmd.mul) begin
			prod_q <= sum_q * MEAN_RECIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q         <= 1'b0;
			armed_q        <= 1'b0;
			count_q        <= '0;
			past_int_q[0]  <= '0;
			past_int_q[1]  <= '0;
			past_rate_q[0] <= '0;
			past_rate_q[1] <= '0;
			latest_q       <= '0;
			mean_q         <= '0;
			status_q       <= ST_VERY_LOW;
			skip_q         <= 1'b0;
		end else if (cmd.eval) begin
			if (cmd_q == CMD_CLEAR) begin
				skip_q <= 1'b0;
				beat_q <= 1'b0;
			end else if (beat_now) begin
				beat_q <= 1'b1;
			end else begin
				beat_q  <= 1'b0;
				count_q <= next_count;
				if (rearm) begin
					armed_q <= 1'b0;
				end
			end
		end else if (cmd.fin) begin
			armed_q        <= 1'b1;
			count_q        <= '0;
			skip_q         <= skip_next;
			mean_q         <= prod_q[MEAN_SHIFT +: RATE_W];
			past_int_q[0]  <= past_int_q[1];
			past_int_q[1]  <= divisor_q;
			past_rate_q[0] <= past_rate_q[1];
			past_rate_q[1] <= quot;
			latest_q       <= quot;
			status_q       <= skip_next ? ST_SKIPPED : band;
		end
	end

	// result register, holds while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			out_beat_q    <= beat_q;
			out_rate_q    <= latest_q;
			out_mean_q    <= mean_q;
			out_status_q  <= status_q;
			out_skipped_q <= skip_q;
		end
	end

	assign stat.beat_now = beat_now;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_beat    = out_beat_q;
	assign out_rate    = out_rate_q;
	assign out_mean    = out_mean_q;
	assign out_status  = out_status_q;
	assign out_skipped = out_skipped_q;

endmodule

// File: rtl/core/prd_ctrl.sv
// sequencing state machine of the pulse rate detector core
module prd_ctrl import prd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.beat_now) begin
					cmd.div_start = 1'b1;
					step_d        = '0;
					state_d       = S_DIV;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_W'(RATE_W - 1)) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (stat.out_free) begin
					cmd.write = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sim/pulse_rate_detector_core_tb.sv
`timescale 1ns / 1ps
// testbench for the pulse rate detector core: beat, rate, mean, band and skip flag per transfer
module pulse_rate_detector_core_tb;
	import prd_pkg::*;

	localparam int COUNT_W = 16;
	localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
	localparam int MAX_WAIT = 18;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PASS_ITEMS = 30;
	localparam int LONG_GAP = 40;

	typedef struct {
		logic              beat;
		logic [RATE_W-1:0] rate_bpm;
		logic [RATE_W-1:0] mean_bpm;
		rate_status_t      status;
		logic              skipped;
	} report_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [INDEX_W-1:0] wr_index;
	logic [CFG_W-1:0]   wr_data;

	prd_in_if  feed_if ();
	prd_out_if report_if ();

	pulse_rate_detector_core #(.COUNT_WIDTH(COUNT_W)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed_if),
		.report   (report_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// predicted detector state
	cfg_t              cfg;
	logic              armed_high;
	int unsigned       interval_count;
	int unsigned       past_interval [2];
	int unsigned       past_rate [2];
	logic [RATE_W-1:0] latest_rate;
	logic [RATE_W-1:0] mean_rate;
	rate_status_t      rate_status;
	logic              skip_flag;

	report_t awaited_reports [$];

	int fail_count = 0;
	int transfers_in = 0;
	int beats_seen = 0;
	int settings_used = 1;
	int feed_gap_max = 0;
	int report_stall_max = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rate_status_t band_of(logic [RATE_W-1:0] r);
		if (r < cfg.band_low) return ST_VERY_LOW;
		if (r < cfg.band_ok) return ST_LOW;
		if (r < cfg.band_high) return ST_OK;
		if (r < cfg.band_very_high) return ST_HIGH;
		return ST_VERY_HIGH;
	endfunction

	function automatic report_t predict_report(logic cmd, logic [SAMPLE_W-1:0] smp);
		report_t     r;
		int unsigned next_iv;
		int unsigned rate;
		int unsigned num;
		r.beat = 1'b0;
		if (cmd == CMD_CLEAR) begin
			skip_flag = 1'b0;
		end else begin
			next_iv = (interval_count < COUNT_MAX) ? interval_count + 1 : COUNT_MAX;
			if (!armed_high && smp > cfg.beat_threshold) begin
				num = cfg.rate_numerator;
				rate = num / next_iv;
				r.beat = 1'b1;
				armed_high = 1'b1;
				if (5 * next_iv >= 9 * past_interval[1] && 5 * next_iv >= 9 * past_interval[0])
					skip_flag = 1'b1;
				mean_rate = RATE_W'((past_rate[0] + past_rate[1] + rate) / 3);
				past_interval[0] = past_interval[1];
				past_interval[1] = next_iv;
				past_rate[0] = past_rate[1];
				past_rate[1] = rate;
				latest_rate = RATE_W'(rate);
				rate_status = skip_flag ? ST_SKIPPED : band_of(latest_rate);
				interval_count = 0;
			end else begin
				interval_count = next_iv;
				if (armed_high && int'(smp) + int'(cfg.hysteresis) < int'(cfg.beat_threshold))
					armed_high = 1'b0;
			end
		end
		r.rate_bpm = latest_rate;
		r.mean_bpm = mean_rate;
		r.status = rate_status;
		r.skipped = skip_flag;
		return r;
	endfunction

	task automatic send_item(logic cmd, logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = $urandom_range(0, feed_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			feed_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		feed_if.valid   <= 1'b1;
		feed_if.command <= cmd;
		feed_if.sample  <= smp;
		do @(posedge clk); while (!feed_if.ready);
		awaited_reports.push_back(predict_report(cmd, smp));
		transfers_in++;
	endtask

	// low stretch (with some dead band samples) followed by a high stretch
	task automatic send_pulse(int low_len, int high_len);
		int thr;
		int hyst;
		thr = cfg.beat_threshold;
		hyst = cfg.hysteresis;
		repeat (low_len) begin
			if ($urandom_range(0, 5) == 0 && thr >= hyst)
				send_item(CMD_SAMPLE, SAMPLE_W'($urandom_range(thr - hyst, thr)));
			else if (thr > hyst)
				send_item(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, thr - hyst - 1)));
			else
				send_item(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 4095)));
		end
		repeat (high_len)
			send_item(CMD_SAMPLE, (thr < 4095) ? SAMPLE_W'($urandom_range(thr + 1, 4095))
				: SAMPLE_W'(4095));
	endtask

	task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_BEAT_THRESHOLD: cfg.beat_threshold = data[SAMPLE_W-1:0];
			REG_HYSTERESIS:     cfg.hysteresis = data[SAMPLE_W-1:0];
			REG_RATE_NUMERATOR: cfg.rate_numerator = data;
			REG_BAND_LOW:       cfg.band_low = data;
			REG_BAND_OK:        cfg.band_ok = data;
			REG_BAND_HIGH:      cfg.band_high = data;
			REG_BAND_VERY_HIGH: cfg.band_very_high = data;
			default: ;
		endcase
	endtask

	// upper bits of the 12-bit registers carry junk
	task automatic program_settings(int unsigned thr, int unsigned hyst, int unsigned num,
		int unsigned lo, int unsigned ok, int unsigned hi, int unsigned vhi);
		write_reg(REG_BEAT_THRESHOLD, {4'($urandom_range(0, 15)), SAMPLE_W'(thr)});
		write_reg(REG_HYSTERESIS, {4'($urandom_range(0, 15)), SAMPLE_W'(hyst)});
		write_reg(REG_RATE_NUMERATOR, CFG_W'(num));
		write_reg(REG_BAND_LOW, CFG_W'(lo));
		write_reg(REG_BAND_OK, CFG_W'(ok));
		write_reg(REG_BAND_HIGH, CFG_W'(hi));
		write_reg(REG_BAND_VERY_HIGH, CFG_W'(vhi));
		@(negedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic settle();
		@(negedge clk);
		feed_if.valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		feed_gap_max = 2;
		report_stall_max = 2;
		send_item(CMD_SAMPLE, 12'd0);
		send_item(CMD_SAMPLE, 12'd4095);
		send_item(CMD_SAMPLE, 12'd2650);
		send_item(CMD_SAMPLE, 12'd2550);
		send_item(CMD_SAMPLE, 12'd2549);
		send_item(CMD_SAMPLE, 12'd2650);
		send_item(CMD_SAMPLE, 12'd2651);
		send_item(CMD_CLEAR, 12'd4095);
		send_item(CMD_CLEAR, 12'd0);
		repeat (3) send_item(CMD_SAMPLE, 12'd0);
		send_item(CMD_SAMPLE, 12'hAAA);
		send_item(CMD_SAMPLE, 12'h555);
		send_item(CMD_SAMPLE, 12'hFFF);
		settle();
	endtask

	task automatic test_register_extremes();
		feed_gap_max = MAX_WAIT;
		report_stall_max = MAX_WAIT;
		// zero threshold and hysteresis: the detector never re-arms, so beats at most once
		program_settings(0, 0, 65535, 0, 0, 0, 0);
		send_item(CMD_SAMPLE, 12'd0);
		send_item(CMD_SAMPLE, 12'd1);
		send_item(CMD_SAMPLE, 12'd0);
		settle();
		// top threshold can never be crossed
		program_settings(4095, 4095, 1, 65535, 65535, 65535, 65535);
		send_item(CMD_SAMPLE, 12'd4095);
		settle();
		// bands out of order
		program_settings(1000, 0, 600, 200, 100, 50, 400);
		send_item(CMD_CLEAR, 12'd0);
		send_pulse(1, 1);
		send_pulse(2, 1);
		send_pulse(3, 1);
		send_pulse(5, 1);
		settle();
	endtask

	task automatic test_random_pulse_trains();
		int unsigned thr;
		int unsigned hyst;
		int unsigned num;
		int unsigned tmp;
		int unsigned b [4];
		int start;
		for (int p = 0; p < 10; p++) begin
			thr  = (p == 0) ? 4095 : $urandom_range(400, 3600);
			hyst = (p == 1) ? 4095 : (p == 2) ? 0 : $urandom_range(0, 600);
			num  = (p == 3) ? 1 : (p == 4) ? 65535 : $urandom_range(2, 65535);
			for (int i = 0; i < 4; i++) begin
				if (p == 5) b[i] = 0;
				else if (p == 6) b[i] = 65535;
				else if (p == 9) b[i] = $urandom_range(0, 65535);
				else b[i] = $urandom_range(0, num / 2 + 1);
			end
			if (p != 9) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3 - i; j++)
						if (b[j] > b[j + 1]) begin
							tmp = b[j];
							b[j] = b[j + 1];
							b[j + 1] = tmp;
						end
			end
			program_settings(thr, hyst, num, b[0], b[1], b[2], b[3]);
			feed_gap_max = (p % 2 == 1) ? MAX_WAIT : 0;
			report_stall_max = ((p / 2) % 2 == 1) ? MAX_WAIT : 0;
			start = transfers_in;
			while (transfers_in - start < PASS_ITEMS) begin
				case ($urandom_range(0, 9))
					7: send_item(CMD_CLEAR, SAMPLE_W'($urandom_range(0, 4095)));
					8, 9: send_item(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 4095)));
					default: begin
						if ($urandom_range(0, 4) == 0)
							send_pulse($urandom_range(15, 40), $urandom_range(1, 3));
						else
							send_pulse($urandom_range(1, 10), $urandom_range(1, 3));
					end
				endcase
			end
			settle();
		end
	endtask

	task automatic test_long_interval();
		program_settings(2000, 100, 65535, 0, 1, 2, 3);
		feed_gap_max = 0;
		report_stall_max = 0;
		send_item(CMD_SAMPLE, 12'd0);
		repeat (LONG_GAP) send_item(CMD_SAMPLE, 12'd0);
		send_item(CMD_SAMPLE, 12'd4095);
		send_item(CMD_SAMPLE, 12'd0);
		send_item(CMD_SAMPLE, 12'd4095);
		settle();
	endtask

	function automatic void check_field(string name, logic [RATE_W-1:0] want,
		logic [RATE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin : receiver
		report_t want;
		int      stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			report_if.ready <= (stall_left == 0);
			if (stall_left != 0) stall_left--;
			@(posedge clk);
			if (arst_n && report_if.valid && report_if.ready) begin
				if (awaited_reports.size() == 0) begin
					$error("report transfer with no item outstanding");
					fail_count++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("beat", RATE_W'(want.beat), RATE_W'(report_if.beat));
					check_field("rate_bpm", want.rate_bpm, report_if.rate_bpm);
					check_field("mean_bpm", want.mean_bpm, report_if.mean_bpm);
					check_field("status", RATE_W'(want.status), RATE_W'(report_if.status));
					check_field("skipped", RATE_W'(want.skipped), RATE_W'(report_if.skipped));
					if (want.beat) beats_seen++;
				end
				stall_left = $urandom_range(0, report_stall_max);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (feed_if.valid && feed_if.ready) || (report_if.valid && report_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("pulse_rate_detector_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : sequencer
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_BEAT_THRESHOLD;
		wr_data = '0;
		feed_if.valid = 1'b0;
		feed_if.command = CMD_SAMPLE;
		feed_if.sample = '0;
		report_if.ready = 1'b0;
		cfg.beat_threshold = 12'd2650;
		cfg.hysteresis = 12'd100;
		cfg.rate_numerator = 16'd12000;
		cfg.band_low = 16'd30;
		cfg.band_ok = 16'd45;
		cfg.band_high = 16'd80;
		cfg.band_very_high = 16'd100;
		armed_high = 1'b0;
		interval_count = 0;
		past_interval[0] = 0;
		past_interval[1] = 0;
		past_rate[0] = 0;
		past_rate[1] = 0;
		latest_rate = '0;
		mean_rate = '0;
		rate_status = ST_VERY_LOW;
		skip_flag = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_random_pulse_trains();
		test_long_interval();

		$display("run covered %0d transfers in, %0d beats, %0d register settings",
			transfers_in, beats_seen, settings_used);
		$display("dead band, re-arm, clear, skipped beats, band order and a long interval");
		if (fail_count == 0 && awaited_reports.size() == 0) begin
			$display("pulse_rate_detector_core: match");
		end else begin
			$display("pulse_rate_detector_core: mismatch");
		end
		$finish;
	end

endmodule
